// ===== design/mfbu_pkg.sv =====
// Shared types, constants and register codes for the motion field bilinear upsampler.
package mfbu_pkg;

	// Block geometry and frame limits.
	localparam int BLK_EDGE       = 16;
	localparam int BLOCK_SHIFT    = $clog2(BLK_EDGE);
	localparam int BLK_CENTRE     = BLK_EDGE / 2;
	localparam int MAX_WIDTH      = 512;
	localparam int MAX_HEIGHT     = 512;
	localparam int MAX_BLOCKS_DEF = 1024;

	// Field widths.
	localparam int SIZE_W  = 10;
	localparam int CNT_W   = 6;
	localparam int POS_W   = 9;
	localparam int IDX_W   = 10;
	localparam int COMP_W  = 8;
	localparam int RES_W   = 16;
	localparam int ADDR_W  = 2 * CNT_W;
	localparam int FRAC_W  = BLOCK_SHIFT;
	localparam int WGT_W   = BLOCK_SHIFT + 1;
	localparam int CIDX_W  = 3;

	// Request commands.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Configuration register indexes.
	typedef enum logic [CIDX_W-1:0] {
		CFG_FRAME_WIDTH  = 3'd0,
		CFG_FRAME_HEIGHT = 3'd1,
		CFG_BLOCKS_ACROSS = 3'd2,
		CFG_BLOCKS_DOWN  = 3'd3,
		CFG_FIELD_VALID  = 3'd4
	} cfg_reg_t;

	// Configuration register contents.
	typedef struct packed {
		logic [SIZE_W-1:0] frame_width;
		logic [SIZE_W-1:0] frame_height;
		logic [CNT_W-1:0]  blocks_across;
		logic [CNT_W-1:0]  blocks_down;
		logic              field_valid;
	} cfg_t;

	// One request item.
	typedef struct packed {
		logic                     command;
		logic [IDX_W-1:0]         entry_index;
		logic signed [COMP_W-1:0] forward_x_motion;
		logic signed [COMP_W-1:0] forward_y_motion;
		logic signed [COMP_W-1:0] backward_x_motion;
		logic signed [COMP_W-1:0] backward_y_motion;
		logic [POS_W-1:0]         pixel_x;
		logic [POS_W-1:0]         pixel_y;
		logic                     use_forward;
	} req_t;

	// One result item.
	typedef struct packed {
		logic signed [RES_W-1:0] motion_x_scaled;
		logic signed [RES_W-1:0] motion_y_scaled;
	} res_t;

	// One stored motion field entry.
	typedef struct packed {
		logic signed [COMP_W-1:0] fwd_x;
		logic signed [COMP_W-1:0] fwd_y;
		logic signed [COMP_W-1:0] bwd_x;
		logic signed [COMP_W-1:0] bwd_y;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Located request leaving the address stages.
	typedef struct packed {
		logic              command;
		logic [IDX_W-1:0]  entry_index;
		entry_t            wdata;
		logic              use_forward;
		logic [ADDR_W-1:0] addr_top;
		logic [ADDR_W-1:0] addr_bot;
		logic              step_x;
		logic [FRAC_W-1:0] frac_x;
		logic [FRAC_W-1:0] frac_y;
	} loc_t;

	// One selected motion vector.
	typedef struct packed {
		logic signed [COMP_W-1:0] x;
		logic signed [COMP_W-1:0] y;
	} vec_t;

	// Four neighbouring vectors and the fractions that weight them.
	typedef struct packed {
		vec_t              v00;
		vec_t              v01;
		vec_t              v10;
		vec_t              v11;
		logic [FRAC_W-1:0] frac_x;
		logic [FRAC_W-1:0] frac_y;
	} blend_in_t;

endpackage

// ===== design/mfbu_field_mem.sv =====
// Motion field memory with one write port and two registered read ports.
module mfbu_field_mem #(
	parameter int DEPTH = mfbu_pkg::MAX_BLOCKS_DEF,
	parameter int AW    = 10,
	parameter int W     = mfbu_pkg::ENTRY_W
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr0,
	input  logic [AW-1:0] raddr1,
	output logic [W-1:0]  rdata0,
	output logic [W-1:0]  rdata1
);

	logic [W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Both read ports capture together, held while the consumer is stalled.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

// ===== design/mfbu_locate.sv =====
// Address stages: position clamping, block split and neighbour address generation.
module mfbu_locate (
	input  logic           clk,
	input  logic           arst_n,
	input  mfbu_pkg::cfg_t cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  mfbu_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output mfbu_pkg::loc_t out_data
);

	logic en_s1, en_s2, en_s3;
	logic valid_s1, valid_s2, valid_s3;

	logic [mfbu_pkg::SIZE_W-1:0] lim_w, lim_h;
	logic [mfbu_pkg::POS_W-1:0]  x_clamp, y_clamp;

	logic                        cmd_s1, fwd_s1;
	logic [mfbu_pkg::IDX_W-1:0]  idx_s1;
	mfbu_pkg::entry_t            wdata_s1;
	logic [mfbu_pkg::POS_W-1:0]  x_s1, y_s1;

	logic [mfbu_pkg::POS_W-1:0]  fxp, fyp;
	logic [mfbu_pkg::CNT_W-1:0]  bx_raw, by_raw, lim_bx, lim_by, bx, by;
	logic                        dx, dy;

	logic                        cmd_s2, fwd_s2, dx_s2, dy_s2;
	logic [mfbu_pkg::IDX_W-1:0]  idx_s2;
	mfbu_pkg::entry_t            wdata_s2;
	logic [mfbu_pkg::CNT_W-1:0]  bx_s2, by_s2;
	logic [mfbu_pkg::FRAC_W-1:0] fx_s2, fy_s2;

	logic [mfbu_pkg::ADDR_W-1:0] row_base, addr_top, addr_bot;
	mfbu_pkg::loc_t              loc_s3;

	// Elastic stage enables: a stage loads when empty or when its successor moves.
	assign en_s3    = !valid_s3 || out_ready;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	// Stage 1: clamp the position to the frame, limited to the largest frame.
	always_comb begin
		lim_w = (cfg.frame_width > mfbu_pkg::SIZE_W'(mfbu_pkg::MAX_WIDTH)) ?
			mfbu_pkg::SIZE_W'(mfbu_pkg::MAX_WIDTH) : cfg.frame_width;
		lim_h = (cfg.frame_height > mfbu_pkg::SIZE_W'(mfbu_pkg::MAX_HEIGHT)) ?
			mfbu_pkg::SIZE_W'(mfbu_pkg::MAX_HEIGHT) : cfg.frame_height;
		if (lim_w == '0) begin
			x_clamp = '0;
		end else if ({1'b0, in_data.pixel_x} >= lim_w) begin
			x_clamp = mfbu_pkg::POS_W'(lim_w - mfbu_pkg::SIZE_W'(1));
		end else begin
			x_clamp = in_data.pixel_x;
		end
		if (lim_h == '0) begin
			y_clamp = '0;
		end else if ({1'b0, in_data.pixel_y} >= lim_h) begin
			y_clamp = mfbu_pkg::POS_W'(lim_h - mfbu_pkg::SIZE_W'(1));
		end else begin
			y_clamp = in_data.pixel_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			cmd_s1         <= in_data.command;
			idx_s1         <= in_data.entry_index;
			wdata_s1.fwd_x <= in_data.forward_x_motion;
			wdata_s1.fwd_y <= in_data.forward_y_motion;
			wdata_s1.bwd_x <= in_data.backward_x_motion;
			wdata_s1.bwd_y <= in_data.backward_y_motion;
			x_s1           <= x_clamp;
			y_s1           <= y_clamp;
			fwd_s1         <= in_data.use_forward;
		end
	end

	// Stage 2: shift back by half a block, split into block and fraction, clamp the block.
	always_comb begin
		fxp = (x_s1 > mfbu_pkg::POS_W'(mfbu_pkg::BLK_CENTRE)) ?
			x_s1 - mfbu_pkg::POS_W'(mfbu_pkg::BLK_CENTRE) : '0;
		fyp = (y_s1 > mfbu_pkg::POS_W'(mfbu_pkg::BLK_CENTRE)) ?
			y_s1 - mfbu_pkg::POS_W'(mfbu_pkg::BLK_CENTRE) : '0;
		bx_raw = mfbu_pkg::CNT_W'(fxp[mfbu_pkg::POS_W-1:mfbu_pkg::BLOCK_SHIFT]);
		by_raw = mfbu_pkg::CNT_W'(fyp[mfbu_pkg::POS_W-1:mfbu_pkg::BLOCK_SHIFT]);
		lim_bx = cfg.blocks_across - mfbu_pkg::CNT_W'(1);
		lim_by = cfg.blocks_down - mfbu_pkg::CNT_W'(1);
		bx = (bx_raw > lim_bx) ? lim_bx : bx_raw;
		by = (by_raw > lim_by) ? lim_by : by_raw;
		dx = ({1'b0, bx} + (mfbu_pkg::CNT_W+1)'(1)) < {1'b0, cfg.blocks_across};
		dy = ({1'b0, by} + (mfbu_pkg::CNT_W+1)'(1)) < {1'b0, cfg.blocks_down};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			cmd_s2   <= cmd_s1;
			idx_s2   <= idx_s1;
			wdata_s2 <= wdata_s1;
			fwd_s2   <= fwd_s1;
			bx_s2    <= bx;
			by_s2    <= by;
			dx_s2    <= dx;
			dy_s2    <= dy;
			// In the last column or row the fraction is zero.
			fx_s2    <= dx ? fxp[mfbu_pkg::FRAC_W-1:0] : '0;
			fy_s2    <= dy ? fyp[mfbu_pkg::FRAC_W-1:0] : '0;
		end
	end

	// Stage 3: linear addresses of the upper-left and lower-left neighbours.
	always_comb begin
		row_base = mfbu_pkg::ADDR_W'(by_s2) * mfbu_pkg::ADDR_W'(cfg.blocks_across);
		addr_top = row_base + mfbu_pkg::ADDR_W'(bx_s2);
		addr_bot = addr_top + (dy_s2 ? mfbu_pkg::ADDR_W'(cfg.blocks_across) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			loc_s3.command     <= cmd_s2;
			loc_s3.entry_index <= idx_s2;
			loc_s3.wdata       <= wdata_s2;
			loc_s3.use_forward <= fwd_s2;
			loc_s3.addr_top    <= addr_top;
			loc_s3.addr_bot    <= addr_bot;
			loc_s3.step_x      <= dx_s2;
			loc_s3.frac_x      <= fx_s2;
			loc_s3.frac_y      <= fy_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = loc_s3;

endmodule

// ===== design/mfbu_blend.sv =====
// Bilinear weighting stages and the result register.
module mfbu_blend (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                field_ok,
	input  logic                in_valid,
	output logic                in_ready,
	input  mfbu_pkg::blend_in_t in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output mfbu_pkg::res_t      out_data
);

	localparam int ROW_W = mfbu_pkg::COMP_W + mfbu_pkg::WGT_W + 1;
	localparam int SUM_W = ROW_W + mfbu_pkg::WGT_W + 1;

	logic en_s5, en_s6;
	logic valid_s5, valid_s6;

	logic [mfbu_pkg::WGT_W-1:0]  wx_near, wx_far, wy_far;
	logic signed [ROW_W-1:0]     wxn_ext, wxf_ext;
	logic signed [ROW_W-1:0]     top_x, bot_x, top_y, bot_y;
	logic signed [ROW_W-1:0]     top_x_s5, bot_x_s5, top_y_s5, bot_y_s5;
	logic [mfbu_pkg::WGT_W-1:0]  wy_near_s5, wy_far_s5;
	logic signed [SUM_W-1:0]     wyn_ext, wyf_ext;
	logic signed [SUM_W-1:0]     sum_x, sum_y;
	mfbu_pkg::res_t              res_s6;

	// Clamp a weighted sum into the result range.
	function automatic logic signed [mfbu_pkg::RES_W-1:0] sat(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi, lo;
		hi = SUM_W'((1 << (mfbu_pkg::RES_W - 1)) - 1);
		lo = -SUM_W'(1 << (mfbu_pkg::RES_W - 1));
		if (v > hi) begin
			return mfbu_pkg::RES_W'(hi);
		end else if (v < lo) begin
			return mfbu_pkg::RES_W'(lo);
		end
		return mfbu_pkg::RES_W'(v);
	endfunction

	// Elastic stage enables.
	assign en_s6    = !valid_s6 || out_ready;
	assign en_s5    = !valid_s5 || en_s6;
	assign in_ready = en_s5;

	// Stage 5: horizontal blend of the upper and lower neighbour pairs.
	always_comb begin
		wx_far  = mfbu_pkg::WGT_W'(in_data.frac_x);
		wx_near = mfbu_pkg::WGT_W'(mfbu_pkg::BLK_EDGE) - wx_far;
		wy_far  = mfbu_pkg::WGT_W'(in_data.frac_y);
		wxn_ext = ROW_W'($signed({1'b0, wx_near}));
		wxf_ext = ROW_W'($signed({1'b0, wx_far}));
		top_x = ROW_W'(in_data.v00.x) * wxn_ext + ROW_W'(in_data.v01.x) * wxf_ext;
		bot_x = ROW_W'(in_data.v10.x) * wxn_ext + ROW_W'(in_data.v11.x) * wxf_ext;
		top_y = ROW_W'(in_data.v00.y) * wxn_ext + ROW_W'(in_data.v01.y) * wxf_ext;
		bot_y = ROW_W'(in_data.v10.y) * wxn_ext + ROW_W'(in_data.v11.y) * wxf_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en_s5) begin
			valid_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			top_x_s5   <= top_x;
			bot_x_s5   <= bot_x;
			top_y_s5   <= top_y;
			bot_y_s5   <= bot_y;
			wy_far_s5  <= wy_far;
			wy_near_s5 <= mfbu_pkg::WGT_W'(mfbu_pkg::BLK_EDGE) - wy_far;
		end
	end

	// Stage 6: vertical blend, saturation and the invalid-field override.
	always_comb begin
		wyn_ext = SUM_W'($signed({1'b0, wy_near_s5}));
		wyf_ext = SUM_W'($signed({1'b0, wy_far_s5}));
		sum_x = SUM_W'(top_x_s5) * wyn_ext + SUM_W'(bot_x_s5) * wyf_ext;
		sum_y = SUM_W'(top_y_s5) * wyn_ext + SUM_W'(bot_y_s5) * wyf_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en_s6) begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			res_s6.motion_x_scaled <= field_ok ? sat(sum_x) : '0;
			res_s6.motion_y_scaled <= field_ok ? sat(sum_y) : '0;
		end
	end

	assign out_valid = valid_s6;
	assign out_data  = res_s6;

endmodule

// ===== design/motion_field_bilinear_upsampler.sv =====
// Top level of the motion field bilinear upsampler: configuration, field memory and pipeline.
//
// Channel  | Handshake             | Payload
// ---------+-----------------------+---------------------------------------------
// request  | req_valid / req_stall | req_data: field write or position query
// result   | res_valid / res_stall | res_data: scaled x and y motion per query
// config   | cfg_valid / cfg_ready | cfg_index, cfg_data: register write
//
// One request is taken every cycle unless req_stall is high; a query's result leaves from stage 6.
// A field write lands in memory at the fourth stage, before any later query reads it.
// Each query reads all four entries together through two dual-read copies of the field.
// Reset loads the configuration defaults and clears all stage valid bits, but not the field.
// A stalled result holds its stage; earlier stages keep filling until every stage is full.
module motion_field_bilinear_upsampler #(
	parameter int MAX_BLOCKS = mfbu_pkg::MAX_BLOCKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  mfbu_pkg::req_t                req_data,
	output logic                          res_valid,
	input  logic                          res_stall,
	output mfbu_pkg::res_t                res_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mfbu_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [mfbu_pkg::SIZE_W-1:0]   cfg_data
);

	localparam int AW     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int LIM_W  = mfbu_pkg::ADDR_W + 1;

	mfbu_pkg::cfg_t      cfg_q;
	logic                field_ok;

	logic                loc_valid, loc_ready, blend_ready;
	mfbu_pkg::loc_t      loc;

	logic                en_s4, valid_s4, fwd_s4;
	logic [3:0]          oor_s4;
	logic [mfbu_pkg::FRAC_W-1:0] fx_s4, fy_s4;

	logic [mfbu_pkg::ADDR_W-1:0] addr_00, addr_01, addr_10, addr_11;
	logic                mem_we, mem_re;
	logic [mfbu_pkg::ENTRY_W-1:0] rd_00, rd_01, rd_10, rd_11;
	mfbu_pkg::blend_in_t blend_in;

	// Pick the requested direction from an entry; an address beyond the field reads as zero.
	function automatic mfbu_pkg::vec_t pick(input logic [mfbu_pkg::ENTRY_W-1:0] raw,
			input logic fwd, input logic oor);
		mfbu_pkg::entry_t e;
		mfbu_pkg::vec_t   v;
		e = mfbu_pkg::entry_t'(raw);
		if (oor) begin
			v = '0;
		end else if (fwd) begin
			v.x = e.fwd_x;
			v.y = e.fwd_y;
		end else begin
			v.x = e.bwd_x;
			v.y = e.bwd_y;
		end
		return v;
	endfunction

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width   <= mfbu_pkg::SIZE_W'(512);
			cfg_q.frame_height  <= mfbu_pkg::SIZE_W'(512);
			cfg_q.blocks_across <= mfbu_pkg::CNT_W'(32);
			cfg_q.blocks_down   <= mfbu_pkg::CNT_W'(32);
			cfg_q.field_valid   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (mfbu_pkg::cfg_reg_t'(cfg_index))
				mfbu_pkg::CFG_FRAME_WIDTH:   cfg_q.frame_width   <= cfg_data;
				mfbu_pkg::CFG_FRAME_HEIGHT:  cfg_q.frame_height  <= cfg_data;
				mfbu_pkg::CFG_BLOCKS_ACROSS: cfg_q.blocks_across <= cfg_data[mfbu_pkg::CNT_W-1:0];
				mfbu_pkg::CFG_BLOCKS_DOWN:   cfg_q.blocks_down   <= cfg_data[mfbu_pkg::CNT_W-1:0];
				mfbu_pkg::CFG_FIELD_VALID:   cfg_q.field_valid   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign field_ok = cfg_q.field_valid && (cfg_q.blocks_across != '0) &&
		(cfg_q.blocks_down != '0);

	// Stages 1 to 3: clamp, split and address generation.
	mfbu_locate u_locate (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (req_valid),
		.in_ready  (loc_ready),
		.in_data   (req_data),
		.out_valid (loc_valid),
		.out_ready (en_s4),
		.out_data  (loc)
	);

	assign req_stall = !loc_ready;

	// Stage 4: field memory access; writes end here, queries read four neighbours.
	assign en_s4   = !valid_s4 || blend_ready;
	assign addr_00 = loc.addr_top;
	assign addr_01 = loc.addr_top + mfbu_pkg::ADDR_W'(loc.step_x);
	assign addr_10 = loc.addr_bot;
	assign addr_11 = loc.addr_bot + mfbu_pkg::ADDR_W'(loc.step_x);
	assign mem_we  = en_s4 && loc_valid && (loc.command == mfbu_pkg::CMD_WRITE) &&
		({3'b000, loc.entry_index} < LIM_W'(MAX_BLOCKS));
	assign mem_re  = en_s4 && loc_valid && (loc.command == mfbu_pkg::CMD_QUERY);

	mfbu_field_mem #(
		.DEPTH (MAX_BLOCKS),
		.AW    (AW),
		.W     (mfbu_pkg::ENTRY_W)
	) u_mem_top (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (AW'(loc.entry_index)),
		.wdata  (loc.wdata),
		.re     (mem_re),
		.raddr0 (AW'(addr_00)),
		.raddr1 (AW'(addr_01)),
		.rdata0 (rd_00),
		.rdata1 (rd_01)
	);

	mfbu_field_mem #(
		.DEPTH (MAX_BLOCKS),
		.AW    (AW),
		.W     (mfbu_pkg::ENTRY_W)
	) u_mem_bot (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (AW'(loc.entry_index)),
		.wdata  (loc.wdata),
		.re     (mem_re),
		.raddr0 (AW'(addr_10)),
		.raddr1 (AW'(addr_11)),
		.rdata0 (rd_10),
		.rdata1 (rd_11)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en_s4) begin
			valid_s4 <= loc_valid && (loc.command == mfbu_pkg::CMD_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			fwd_s4    <= loc.use_forward;
			fx_s4     <= loc.frac_x;
			fy_s4     <= loc.frac_y;
			oor_s4[0] <= {1'b0, addr_00} >= LIM_W'(MAX_BLOCKS);
			oor_s4[1] <= {1'b0, addr_01} >= LIM_W'(MAX_BLOCKS);
			oor_s4[2] <= {1'b0, addr_10} >= LIM_W'(MAX_BLOCKS);
			oor_s4[3] <= {1'b0, addr_11} >= LIM_W'(MAX_BLOCKS);
		end
	end

	// Direction select ahead of the blend stages.
	always_comb begin
		blend_in.v00    = pick(rd_00, fwd_s4, oor_s4[0]);
		blend_in.v01    = pick(rd_01, fwd_s4, oor_s4[1]);
		blend_in.v10    = pick(rd_10, fwd_s4, oor_s4[2]);
		blend_in.v11    = pick(rd_11, fwd_s4, oor_s4[3]);
		blend_in.frac_x = fx_s4;
		blend_in.frac_y = fy_s4;
	end

	// Stages 5 and 6: bilinear weighting and the result register.
	mfbu_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.field_ok  (field_ok),
		.in_valid  (valid_s4),
		.in_ready  (blend_ready),
		.in_data   (blend_in),
		.out_valid (res_valid),
		.out_ready (!res_stall),
		.out_data  (res_data)
	);

	// The memory never writes and reads for the same request slot.
	a_mem_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("field memory written and read in the same cycle");

	// With the result side free, the request side is never held back.
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!res_stall |-> !req_stall)
		else $error("request stalled while the result side is free");

	// A write request never produces a result: stage 4 stays empty behind it.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we |=> !valid_s4))
		else $error("field write reached the blend stages");

endmodule
